// ===== sv/framebuffer_draw_engine_top_macros.svh =====
// Assertion macros shared by the framebuffer draw engine RTL.
`ifndef FRAMEBUFFER_DRAW_ENGINE_TOP_MACROS_SVH
`define FRAMEBUFFER_DRAW_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define FDE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define FDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fde_pkg.sv =====
// Package with the types, constants and helpers of the framebuffer draw engine.
`timescale 1ns / 1ps
package fde_pkg;

  localparam int unsigned MAX_WIDTH   = 256;
  localparam int unsigned MAX_HEIGHT  = 256;
  localparam int unsigned DIM_W       = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH :
                                                MAX_HEIGHT) + 1);
  localparam int unsigned ADDR_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned CFG_W       = 9;
  localparam int unsigned PIX_W       = 32;
  localparam int unsigned COORD_W     = 18;
  localparam int unsigned POS_W       = 36;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned RND_W       = POS_W - FRAC_W;
  localparam int unsigned INC_W       = 18;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned NUM_W       = 33;
  localparam int unsigned DEN_W       = LEN_W;
  localparam int unsigned GRID_STEP   = 10;
  localparam logic [PIX_W-1:0] GRID_COLOUR = 32'hFF33_3333;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_PLOT  = 3'd1,
    CMD_LINE  = 3'd2,
    CMD_RECT  = 3'd3,
    CMD_GRID  = 3'd4,
    CMD_READ  = 3'd5
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_DIV_X,
    ST_DIV_Y,
    ST_LINE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [2:0]        command;
    logic signed [15:0] x_first;
    logic signed [15:0] y_first;
    logic signed [15:0] x_second;
    logic signed [15:0] y_second;
    logic [14:0]       rect_width;
    logic [14:0]       rect_height;
    logic [31:0]       colour;
  } cmd_t;

  typedef struct packed {
    logic [31:0] pixel_colour;
    logic        in_frame;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [DIM_W-1:0] x,
                                                 input logic [DIM_W-1:0] y);
    return ADDR_W'(32'(y) * 32'(MAX_WIDTH) + 32'(x));
  endfunction

endpackage

// ===== sv/framebuffer_draw_engine_top.sv =====
// Top level of the framebuffer draw engine: command sequencer, pixel stepping and store.
//
// Channel  Direction  Handshake              Beat
// in       in         in_valid_i/in_stall_o  cmd_t drawing command
// out      out        out_valid_o/out_stall_i res_t pixel read result
// cfg      in         cfg_valid_i/cfg_ready_o frame size register write
//
// Clear, rectangle and grid write one pixel per cycle over the clipped span.
// A line runs two divisions on the shared divider, then steps along its points, writing those in the frame.
// Plot writes when accepted; an in-frame read passes ST_READ; the result then waits in the output register.
// Reset sets the frame to 256 by 256; the pixel store is not cleared.
// Commands are refused while a command runs or a result is still waiting.
`timescale 1ns / 1ps
`include "framebuffer_draw_engine_top_macros.svh"
module framebuffer_draw_engine_top import fde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  cmd_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output res_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  cfg_e       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [CFG_W-1:0] frame_w_q, frame_h_q;
  logic [DIM_W-1:0] eff_w, eff_h;

  logic signed [COORD_W-1:0] cx_q, cx_d, cy_q, cy_d, xa_q, xa_d, xb_q, xb_d, yb_q, yb_d;
  logic                      grid_q, grid_d;
  logic [PIX_W-1:0]          col_q, col_d;

  logic signed [POS_W-1:0] px_q, px_d, py_q, py_d;
  logic signed [INC_W-1:0] ix_q, ix_d, iy_q, iy_d;
  logic [LEN_W-1:0]        cnt_q, cnt_d, len_q, len_d, ay_q, ay_d;
  logic                    sx_q, sx_d, sy_q, sy_d;

  logic out_valid_q, out_valid_d;
  res_t out_q, out_d;

  logic accept;
  cmd_e cmd;
  logic signed [16:0] dx, dy;
  logic [LEN_W-1:0]   ax, ay, len;
  logic signed [COORD_W-1:0] rx_lo, ry_lo, rx_hi, ry_hi, span_step, nx, ny;
  logic signed [POS_W-1:0]   prx, pry;
  logic signed [RND_W-1:0]   lx, ly;
  logic                      line_in, first_in, span_go;
  logic signed [INC_W-1:0]   q_signed;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;

  function automatic logic in_frame_chk(input logic signed [RND_W-1:0] x,
                                        input logic signed [RND_W-1:0] y,
                                        input logic [DIM_W-1:0] w,
                                        input logic [DIM_W-1:0] h);
    return !x[RND_W-1] && !y[RND_W-1] &&
           (x[RND_W-2:0] < (RND_W-1)'(w)) && (y[RND_W-2:0] < (RND_W-1)'(h));
  endfunction

  assign eff_w = DIM_W'((32'(frame_w_q) < MAX_WIDTH) ? 32'(frame_w_q) : MAX_WIDTH);
  assign eff_h = DIM_W'((32'(frame_h_q) < MAX_HEIGHT) ? 32'(frame_h_q) : MAX_HEIGHT);

  assign in_stall_o  = (state_q != ST_IDLE) || out_valid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign cmd         = cmd_e'(in_data_i.command);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    dx    = 17'(in_data_i.x_second) - 17'(in_data_i.x_first);
    dy    = 17'(in_data_i.y_second) - 17'(in_data_i.y_first);
    ax    = dx[16] ? LEN_W'(-dx) : dx[LEN_W-1:0];
    ay    = dy[16] ? LEN_W'(-dy) : dy[LEN_W-1:0];
    len   = (ax >= ay) ? ax : ay;
    rx_lo = in_data_i.x_first[15] ? '0 : COORD_W'(in_data_i.x_first);
    ry_lo = in_data_i.y_first[15] ? '0 : COORD_W'(in_data_i.y_first);
    rx_hi = COORD_W'(in_data_i.x_first) + COORD_W'({1'b0, in_data_i.rect_width});
    ry_hi = COORD_W'(in_data_i.y_first) + COORD_W'({1'b0, in_data_i.rect_height});
    if (rx_hi > $signed(COORD_W'(eff_w))) begin
      rx_hi = COORD_W'(eff_w);
    end
    if (ry_hi > $signed(COORD_W'(eff_h))) begin
      ry_hi = COORD_W'(eff_h);
    end
    first_in  = in_frame_chk(RND_W'(in_data_i.x_first), RND_W'(in_data_i.y_first),
                             eff_w, eff_h);
    span_step = grid_q ? COORD_W'(GRID_STEP) : COORD_W'(1);
    nx        = cx_q + span_step;
    ny        = cy_q + span_step;
    prx       = px_q + POS_W'(32768) - POS_W'(px_q[POS_W-1]);
    pry       = py_q + POS_W'(32768) - POS_W'(py_q[POS_W-1]);
    lx        = prx[POS_W-1:FRAC_W];
    ly        = pry[POS_W-1:FRAC_W];
    line_in   = in_frame_chk(lx, ly, eff_w, eff_h);
    span_go   = (eff_w != '0) && (eff_h != '0);
    q_signed  = {1'b0, div_rsp.quo[INC_W-2:0]};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_CLEAR, CMD_GRID: begin
              if (span_go) begin
                state_d = ST_SPAN;
              end
            end
            CMD_RECT: begin
              if ((rx_lo < rx_hi) && (ry_lo < ry_hi)) begin
                state_d = ST_SPAN;
              end
            end
            CMD_LINE: state_d = (len == '0) ? ST_LINE : ST_DIV_X;
            CMD_READ: begin
              if (first_in) begin
                state_d = ST_READ;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SPAN: begin
        if ((nx >= xb_q) && (ny >= yb_q)) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV_X: begin
        if (div_rsp.done) begin
          state_d = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_rsp.done) begin
          state_d = ST_LINE;
        end
      end
      ST_LINE: begin
        if (cnt_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cx_d = cx_q; cy_d = cy_q; xa_d = xa_q; xb_d = xb_q; yb_d = yb_q;
    grid_d = grid_q; col_d = col_q;
    px_d = px_q; py_d = py_q; ix_d = ix_q; iy_d = iy_q;
    cnt_d = cnt_q; len_d = len_q; ay_d = ay_q; sx_d = sx_q; sy_d = sy_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    div_req     = '0;
    ram_we      = 1'b0;
    ram_addr    = pix_addr(in_data_i.x_first[DIM_W-1:0], in_data_i.y_first[DIM_W-1:0]);
    ram_wdata   = in_data_i.colour;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          col_d = in_data_i.colour;
          unique case (cmd)
            CMD_CLEAR, CMD_GRID: begin
              cx_d   = '0;
              cy_d   = '0;
              xa_d   = '0;
              xb_d   = COORD_W'(eff_w);
              yb_d   = COORD_W'(eff_h);
              grid_d = (cmd == CMD_GRID);
              if (cmd == CMD_GRID) begin
                col_d = GRID_COLOUR;
              end
            end
            CMD_RECT: begin
              cx_d   = rx_lo;
              cy_d   = ry_lo;
              xa_d   = rx_lo;
              xb_d   = rx_hi;
              yb_d   = ry_hi;
              grid_d = 1'b0;
            end
            CMD_PLOT: ram_we = first_in;
            CMD_LINE: begin
              px_d  = {RND_W'(in_data_i.x_first), FRAC_W'(0)};
              py_d  = {RND_W'(in_data_i.y_first), FRAC_W'(0)};
              ix_d  = '0;
              iy_d  = '0;
              cnt_d = len;
              len_d = len;
              ay_d  = ay;
              sx_d  = dx[16];
              sy_d  = dy[16];
              div_req.start = (len != '0);
              div_req.num   = NUM_W'({ax, FRAC_W'(0)}) + NUM_W'(len[LEN_W-1:1]);
              div_req.den   = len;
            end
            CMD_READ: begin
              if (!first_in) begin
                out_valid_d = 1'b1;
                out_d       = '0;
              end
            end
            default: col_d = col_q;
          endcase
        end
      end
      ST_SPAN: begin
        ram_we    = 1'b1;
        ram_addr  = pix_addr(cx_q[DIM_W-1:0], cy_q[DIM_W-1:0]);
        ram_wdata = col_q;
        if (nx >= xb_q) begin
          cx_d = xa_q;
          cy_d = ny;
        end else begin
          cx_d = nx;
        end
      end
      ST_DIV_X: begin
        if (div_rsp.done) begin
          ix_d          = sx_q ? -q_signed : q_signed;
          div_req.start = 1'b1;
          div_req.num   = NUM_W'({ay_q, FRAC_W'(0)}) + NUM_W'(len_q[LEN_W-1:1]);
          div_req.den   = len_q;
        end
      end
      ST_DIV_Y: begin
        if (div_rsp.done) begin
          iy_d = sy_q ? -q_signed : q_signed;
        end
      end
      ST_LINE: begin
        ram_we    = line_in;
        ram_addr  = pix_addr(lx[DIM_W-1:0], ly[DIM_W-1:0]);
        ram_wdata = col_q;
        px_d      = px_q + POS_W'(ix_q);
        py_d      = py_q + POS_W'(iy_q);
        cnt_d     = cnt_q - LEN_W'(1);
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        out_d       = '{pixel_colour: ram_rdata, in_frame: 1'b1};
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      frame_w_q   <= CFG_W'(256);
      frame_h_q   <= CFG_W'(256);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_FRAME_WIDTH:  frame_w_q <= cfg_data_i;
          CFG_FRAME_HEIGHT: frame_h_q <= cfg_data_i;
          default:          frame_w_q <= frame_w_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d; cy_q <= cy_d; xa_q <= xa_d; xb_q <= xb_d; yb_q <= yb_d;
    grid_q <= grid_d; col_q <= col_d;
    px_q <= px_d; py_q <= py_d; ix_q <= ix_d; iy_q <= iy_d;
    cnt_q <= cnt_d; len_q <= len_d; ay_q <= ay_d; sx_q <= sx_d; sy_q <= sy_d;
    out_q <= out_d;
  end

  fde_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  fde_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  `FDE_ASSERT_IMPL(a_div_done_in_div, div_rsp.done, (state_q == ST_DIV_X) || (state_q == ST_DIV_Y), "Divider finished outside a division state.")
  `FDE_ASSERT_NEXT(a_read_gives_beat, state_q == ST_READ, out_valid_q && out_q.in_frame, "Read did not produce an in-frame result.")
  `FDE_ASSERT_IMPL(a_span_in_bounds, state_q == ST_SPAN, !cx_q[COORD_W-1] && (cx_q < xb_q) && (cy_q < yb_q), "Span position left its bounds.")

endmodule

// ===== sv/fde_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module fde_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== sv/fde_div.sv =====
// Iterative restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module fde_div import fde_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W:0]   rem_shift;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    rem_shift = {rem_q, num_q[NUM_W-1]};
    diff      = rem_shift - {1'b0, den_q};
    ge        = rem_shift >= {1'b0, den_q};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    num_d     = num_q;
    quo_d     = quo_q;
    den_d     = den_q;
    rem_d     = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      num_d  = req_i.num;
      den_d  = req_i.den;
      quo_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      num_d = {num_q[NUM_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== verif/fde_checker.sv =====
// Checker for the framebuffer draw engine: tracks the pixel store and compares read results.
`timescale 1ns / 1ps
module fde_checker import fde_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  cmd_t             in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  res_t             out_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  cfg_e             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int               pending_o,
  output int               fail_count_o
);

  logic [PIX_W-1:0] shadow_pixels [MAX_WIDTH*MAX_HEIGHT];
  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  res_t             read_q [$];
  int               fails;

  assign pending_o    = read_q.size();
  assign fail_count_o = fails;

  function automatic longint span_w();
    return (width_q > MAX_WIDTH) ? longint'(MAX_WIDTH) : longint'(width_q);
  endfunction

  function automatic longint span_h();
    return (height_q > MAX_HEIGHT) ? longint'(MAX_HEIGHT) : longint'(height_q);
  endfunction

  function automatic bit on_frame(longint x, longint y);
    return x >= 0 && x < span_w() && y >= 0 && y < span_h();
  endfunction

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) begin
      return (n + d / 2) / d;
    end
    return -((-n + d / 2) / d);
  endfunction

  task automatic paint(longint x, longint y, logic [PIX_W-1:0] c);
    if (on_frame(x, y)) begin
      shadow_pixels[y * MAX_WIDTH + x] = c;
    end
  endtask

  task automatic fill_box(longint x, longint y, longint w, longint h, logic [PIX_W-1:0] c);
    longint xa;
    longint ya;
    longint xb;
    longint yb;
    xa = (x < 0) ? 0 : x;
    ya = (y < 0) ? 0 : y;
    xb = (x + w > span_w()) ? span_w() : x + w;
    yb = (y + h > span_h()) ? span_h() : y + h;
    for (longint j = ya; j < yb; j++) begin
      for (longint i = xa; i < xb; i++) begin
        paint(i, j, c);
      end
    end
  endtask

  task automatic trace_line(longint x0, longint y0, longint x1, longint y1,
                            logic [PIX_W-1:0] c);
    longint dx;
    longint dy;
    longint steps;
    longint inc_x;
    longint inc_y;
    dx = x1 - x0;
    dy = y1 - y0;
    steps = ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy)) ? (dx < 0 ? -dx : dx)
                                                          : (dy < 0 ? -dy : dy);
    if (steps == 0) begin
      paint(x0, y0, c);
    end else begin
      inc_x = round_div(dx * 65536, steps);
      inc_y = round_div(dy * 65536, steps);
      for (longint i = 0; i <= steps; i++) begin
        paint(round_div(x0 * 65536 + i * inc_x, 65536),
              round_div(y0 * 65536 + i * inc_y, 65536), c);
      end
    end
  endtask

  task automatic apply_command(cmd_t cmd);
    res_t r;
    case (cmd.command)
      CMD_CLEAR: fill_box(0, 0, span_w(), span_h(), cmd.colour);
      CMD_PLOT:  paint(cmd.x_first, cmd.y_first, cmd.colour);
      CMD_LINE:  trace_line(cmd.x_first, cmd.y_first, cmd.x_second, cmd.y_second,
                            cmd.colour);
      CMD_RECT:  fill_box(cmd.x_first, cmd.y_first, cmd.rect_width, cmd.rect_height,
                          cmd.colour);
      CMD_GRID: begin
        for (longint j = 0; j < span_h(); j += GRID_STEP) begin
          for (longint i = 0; i < span_w(); i += GRID_STEP) begin
            paint(i, j, GRID_COLOUR);
          end
        end
      end
      CMD_READ: begin
        if (on_frame(cmd.x_first, cmd.y_first)) begin
          r.pixel_colour = shadow_pixels[longint'(cmd.y_first) * MAX_WIDTH
                                         + longint'(cmd.x_first)];
          r.in_frame = 1'b1;
        end else begin
          r.pixel_colour = '0;
          r.in_frame = 1'b0;
        end
        read_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      width_q  <= CFG_W'(MAX_WIDTH);
      height_q <= CFG_W'(MAX_HEIGHT);
      fails    = 0;
      read_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_FRAME_WIDTH) begin
          width_q <= cfg_data_i;
        end else begin
          height_q <= cfg_data_i;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_command(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (read_q.size() == 0) begin
          $error("unexpected result beat: pixel_colour %h in_frame %b",
                 out_data_i.pixel_colour, out_data_i.in_frame);
          fails++;
        end else begin
          want = read_q.pop_front();
          if (out_data_i.pixel_colour !== want.pixel_colour) begin
            $error("pixel_colour: expected %h, got %h", want.pixel_colour,
                   out_data_i.pixel_colour);
            fails++;
          end
          if (out_data_i.in_frame !== want.in_frame) begin
            $error("in_frame: expected %b, got %b", want.in_frame, out_data_i.in_frame);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_framebuffer_draw_engine_top.sv =====
// Testbench top for the framebuffer draw engine: stimulus, stalls and the verdict.
`timescale 1ns / 1ps
module tb_framebuffer_draw_engine_top;
  import fde_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  cmd_t             in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  res_t             out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  cfg_e             cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  int               pending;
  int               fail_count;
  bit               calm;

  framebuffer_draw_engine_top u_dut (.*);

  fde_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("framebuffer_draw_engine_top test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 18);
  end

  function automatic cmd_t make_cmd(logic [2:0] op, int xa, int ya, int xb, int yb,
                                    int w, int h, logic [31:0] c);
    cmd_t cmd;
    cmd.command     = op;
    cmd.x_first     = 16'(xa);
    cmd.y_first     = 16'(ya);
    cmd.x_second    = 16'(xb);
    cmd.y_second    = 16'(yb);
    cmd.rect_width  = 15'(w);
    cmd.rect_height = 15'(h);
    cmd.colour      = c;
    return cmd;
  endfunction

  function automatic int pick_coord(int wide_pct);
    if ($urandom_range(99) < wide_pct) begin
      return int'($signed(16'($urandom)));
    end
    return int'($urandom_range(330)) - 30;
  endfunction

  task automatic send(cmd_t cmd);
    int gap;
    if (!calm && $urandom_range(99) < 18) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  task automatic drain();
    send(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 32'h0));
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(value);
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item();
    int   pick;
    cmd_t cmd;
    pick = $urandom_range(999);
    cmd = make_cmd(CMD_READ, pick_coord(3), pick_coord(3), 0, 0, 0, 0, $urandom);
    cmd.x_second = 16'(pick_coord(1));
    cmd.y_second = 16'(pick_coord(1));
    if ($urandom_range(99) < 4) begin
      cmd.rect_width  = 15'($urandom);
      cmd.rect_height = 15'($urandom);
    end else begin
      cmd.rect_width  = 15'($urandom_range(40));
      cmd.rect_height = 15'($urandom_range(40));
    end
    if (pick < 5) begin
      cmd.command = CMD_CLEAR;
    end else if (pick < 10) begin
      cmd.command = CMD_GRID;
    end else if (pick < 30) begin
      cmd.command = pick[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
    end else if (pick < 280) begin
      cmd.command = CMD_PLOT;
    end else if (pick < 530) begin
      cmd.command = CMD_LINE;
      if ($urandom_range(99) >= 1) begin
        cmd.x_first = 16'(pick_coord(0));
        cmd.y_first = 16'(pick_coord(0));
      end
    end else if (pick < 680) begin
      cmd.command = CMD_RECT;
    end else begin
      cmd.command = CMD_READ;
    end
    send(cmd);
  endtask

  initial begin
    int widths [6]  = '{1, 511, 0, 100, 17, 256};
    int heights [6] = '{1, 300, 5, 37, 0, 256};
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_FRAME_WIDTH;
    cfg_data_i  = '0;
    calm        = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_FRAME_WIDTH, 256);
    write_reg(CFG_FRAME_HEIGHT, 256);
    send(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send(make_cmd(CMD_GRID, 0, 0, 0, 0, 0, 0, 32'h0));
    send(make_cmd(CMD_READ, 10, 20, 0, 0, 0, 0, 32'h0));
    send(make_cmd(CMD_PLOT, 0, 0, 0, 0, 0, 0, 32'h0));
    send(make_cmd(CMD_PLOT, 255, 255, 0, 0, 0, 0, 32'h1234_5678));
    send(make_cmd(CMD_PLOT, -1, 0, 0, 0, 0, 0, 32'hDEAD_BEEF));
    send(make_cmd(CMD_PLOT, 32767, -32768, 0, 0, 0, 0, 32'hDEAD_BEEF));
    send(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 32'h0));
    send(make_cmd(CMD_READ, 255, 255, 0, 0, 0, 0, 32'h0));
    send(make_cmd(CMD_READ, 256, 3, 0, 0, 0, 0, 32'h0));
    send(make_cmd(CMD_READ, -32768, 32767, 0, 0, 0, 0, 32'h0));
    send(make_cmd(CMD_LINE, 7, 9, 7, 9, 0, 0, 32'hA5A5_A5A5));
    send(make_cmd(CMD_LINE, 0, 0, 3, 2, 0, 0, 32'h0F0F_0F0F));
    send(make_cmd(CMD_LINE, 10, 200, 3, -5, 0, 0, 32'h5A5A_5A5A));
    send(make_cmd(CMD_LINE, -32768, -32768, 32767, 32767, 0, 0, 32'h7777_7777));
    send(make_cmd(CMD_RECT, 5, 5, 0, 0, 0, 9, 32'h1111_1111));
    send(make_cmd(CMD_RECT, 5, 5, 0, 0, 3, 4, 32'h2222_2222));
    send(make_cmd(CMD_RECT, -32768, -32768, 0, 0, 32767, 32767, 32'h3333_4444));
    send(make_cmd(CMD_SPARE_LO, 1, 1, 0, 0, 0, 0, 32'h0));
    send(make_cmd(CMD_SPARE_HI, 1, 1, 0, 0, 0, 0, 32'h0));
    send(make_cmd(CMD_READ, 7, 9, 0, 0, 0, 0, 32'h0));
    send(make_cmd(CMD_READ, 6, 8, 0, 0, 0, 0, 32'h0));
    send(make_cmd(CMD_READ, 128, 128, 0, 0, 0, 0, 32'h0));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_FRAME_WIDTH, widths[phase]);
      write_reg(CFG_FRAME_HEIGHT, heights[phase]);
      for (int n = 0; n < 305; n++) begin
        calm = (phase == 3) && (n >= 50) && (n < 250);
        random_item();
      end
      calm = 1'b0;
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("framebuffer_draw_engine_top test passed");
    end else begin
      $display("framebuffer_draw_engine_top test failed");
    end
    $finish;
  end

endmodule
